// ----- sv/cnm_pkg.sv -----
// Shared constants, state types and codes for the cosine nearest match unit.
`default_nettype none
package cnm_pkg;
  localparam int MAX_ENTRIES = 256;
  localparam int MAX_DIM     = 64;

  localparam int ENTRY_W = $clog2(MAX_ENTRIES);
  localparam int COUNT_W = ENTRY_W + 1;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int DCNT_W  = DIM_W + 1;
  localparam int ADDR_W  = ENTRY_W + DIM_W;

  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 8;

  localparam int NRM_W   = 31 + DIM_W;
  localparam int DOT_W   = NRM_W + 1;
  localparam int PRD_W   = 2 * NRM_W;
  localparam int WIDE_W  = PRD_W + 34;
  localparam int M_W     = 16;
  localparam int MCNT_W  = $clog2(NRM_W + 1);

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(64);

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_QUERY    = 1'b1;

  typedef enum logic [2:0] {
    TOP_IDLE,
    TOP_MAC,
    TOP_DRAIN,
    TOP_LAUNCH,
    TOP_WAIT,
    TOP_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    SIM_IDLE,
    SIM_MUL,
    SIM_SQA,
    SIM_SQB,
    SIM_DONE
  } sim_state_t;
endpackage
`default_nettype wire

// ----- sv/cnm_sim_unit.sv -----
// Multi-cycle cosine similarity from dot product and squared norms.
`default_nettype none
module cnm_sim_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               go,
  input  wire logic signed [cnm_pkg::DOT_W-1:0]   dot,
  input  wire logic        [cnm_pkg::NRM_W-1:0]   nq,
  input  wire logic        [cnm_pkg::NRM_W-1:0]   ne,
  output logic                                    done,
  output logic signed      [cnm_pkg::VAL_W-1:0]   sim
);
  import cnm_pkg::*;

  sim_state_t state, state_next;

  logic              neg;
  logic [PRD_W-1:0]  pa, da, pacc, dacc;
  logic [NRM_W-1:0]  pb, db;
  logic [MCNT_W-1:0] cnt;
  logic [3:0]        k;
  logic [WIDE_W-1:0] s_acc, t_acc, cand, p_ext, d_full;
  logic [M_W-1:0]    m;
  logic [DOT_W-1:0]  dot_mag;

  assign dot_mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
  assign p_ext   = WIDE_W'(pacc);
  assign d_full  = WIDE_W'(dacc) << 30;

  always_comb begin
    state_next = state;
    case (state)
      SIM_IDLE: begin
        if (go) state_next = (nq == '0 || ne == '0) ? SIM_DONE : SIM_MUL;
      end
      SIM_MUL:  if (cnt == MCNT_W'(NRM_W - 1)) state_next = SIM_SQA;
      SIM_SQA:  state_next = SIM_SQB;
      SIM_SQB:  state_next = (k == 4'd0) ? SIM_DONE : SIM_SQA;
      SIM_DONE: state_next = SIM_IDLE;
      default:  state_next = SIM_IDLE;
    endcase
  end

  always_comb begin
    done = (state == SIM_DONE);
    if (neg) sim = VAL_W'(-m);
    else if (m[M_W-1]) sim = 16'sh7fff;
    else sim = m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SIM_IDLE: begin
        neg   <= dot[DOT_W-1];
        pa    <= PRD_W'(nq);
        pb    <= ne;
        da    <= PRD_W'(dot_mag[NRM_W-1:0]);
        db    <= dot_mag[NRM_W-1:0];
        pacc  <= '0;
        dacc  <= '0;
        cnt   <= '0;
        k     <= 4'd15;
        s_acc <= '0;
        t_acc <= '0;
        m     <= '0;
      end
      SIM_MUL: begin
        if (pb[0]) pacc <= pacc + pa;
        if (db[0]) dacc <= dacc + da;
        pa  <= pa << 1;
        da  <= da << 1;
        pb  <= pb >> 1;
        db  <= db >> 1;
        cnt <= cnt + MCNT_W'(1);
      end
      SIM_SQA: begin
        cand <= s_acc + (t_acc << ({1'b0, k} + 5'd1)) + (p_ext << {k, 1'b0});
      end
      SIM_SQB: begin
        if (cand <= d_full) begin
          s_acc <= cand;
          t_acc <= t_acc + (p_ext << k);
          m[k]  <= 1'b1;
        end
        k <= k - 4'd1;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/cosine_nearest_match_unit.sv -----
// Top level: vector table, query buffer and the nearest match scan.
//
// Input words are taken at a clock edge where start is high and busy is
// low; cmd selects register (0) or query (1). Each word carries one
// component. A register word writes the next free table entry; the word
// that completes the vector stores producer_id and commits the entry.
// Register words are dropped while the table holds MAX_ENTRIES vectors.
// A register or non-final query word leaves busy low.
// The final query word starts a scan. Per stored entry: memory reads
// and multiply-accumulate, then shift-add multiply, bit-by-bit root
// search and a done state (multiply and root search are skipped when
// either norm is zero). Entries are scanned one at a time through the
// single read port and the serial similarity unit. An empty table
// answers in the cycle after the final word.
// The result appears for one cycle with result_valid; the receiver
// cannot stall it. The configuration channel takes vector_dim at any
// time (cfg_ready is always high) and must only be written while idle.
// Reset clears the table count and component pointer and sets
// vector_dim to 64; memory contents are not cleared.
`default_nettype none
module cosine_nearest_match_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               cmd,
  input  wire logic signed [cnm_pkg::VAL_W-1:0]   component_value,
  input  wire logic        [cnm_pkg::PROD_W-1:0]  producer_id,
  output logic                                    result_valid,
  output logic                                    found,
  output logic             [cnm_pkg::IDX_W-1:0]   best_index,
  output logic             [cnm_pkg::PROD_W-1:0]  best_producer,
  output logic signed      [cnm_pkg::VAL_W-1:0]   similarity,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic        [cnm_pkg::CFG_W-1:0]   cfg_data
);
  import cnm_pkg::*;

  top_state_t state, state_next;

  logic [VAL_W-1:0]  entry_store [MAX_ENTRIES*MAX_DIM];
  logic [PROD_W-1:0] entry_producers [MAX_ENTRIES];
  logic [VAL_W-1:0]  query_buffer [MAX_DIM];

  logic [CFG_W-1:0]   vector_dim;
  logic [COUNT_W-1:0] entry_count;
  logic [DIM_W-1:0]   ptr;
  logic [DIM_W-1:0]   j;
  logic [ENTRY_W-1:0] idx;
  logic               rd_v;
  logic [VAL_W-1:0]   e_rdata, q_rdata;
  logic [PROD_W-1:0]  p_rdata;

  logic signed [DOT_W-1:0] dot;
  logic [NRM_W-1:0]        nq, ne;

  logic                     found_r;
  logic [ENTRY_W-1:0]       best_idx;
  logic [PROD_W-1:0]        best_prod;
  logic signed [VAL_W-1:0]  best_sim;

  logic [DCNT_W-1:0]  dim_eff;
  logic               accept, is_last, full, scan_go, acc_clr, more;
  logic               sim_go, sim_done;
  logic signed [VAL_W-1:0]  sim;
  logic signed [VAL_W-1:0]  qv, ev;
  logic signed [2*VAL_W-1:0] qe, qq, ee;

  always_comb begin
    if (vector_dim == '0) dim_eff = DCNT_W'(1);
    else if (DCNT_W'(vector_dim) > DCNT_W'(MAX_DIM)) dim_eff = DCNT_W'(MAX_DIM);
    else dim_eff = DCNT_W'(vector_dim);
  end

  assign busy    = (state != TOP_IDLE);
  assign accept  = start && !busy;
  assign is_last = ({1'b0, ptr} + DCNT_W'(1)) >= dim_eff;
  assign full    = entry_count >= COUNT_W'(MAX_ENTRIES);
  assign scan_go = accept && cmd == CMD_QUERY && is_last;
  assign more    = ({1'b0, idx} + COUNT_W'(1)) < entry_count;
  assign sim_go  = (state == TOP_LAUNCH);
  assign acc_clr = (state_next == TOP_MAC) && (state != TOP_MAC);

  always_comb begin
    state_next = state;
    case (state)
      TOP_IDLE:   if (scan_go) state_next = (entry_count == '0) ? TOP_DONE : TOP_MAC;
      TOP_MAC:    if (({1'b0, j} + DCNT_W'(1)) >= dim_eff) state_next = TOP_DRAIN;
      TOP_DRAIN:  state_next = TOP_LAUNCH;
      TOP_LAUNCH: state_next = TOP_WAIT;
      TOP_WAIT:   if (sim_done) state_next = more ? TOP_MAC : TOP_DONE;
      TOP_DONE:   state_next = TOP_IDLE;
      default:    state_next = TOP_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready     = 1'b1;
    result_valid  = (state == TOP_DONE);
    found         = found_r;
    best_index    = found_r ? IDX_W'(best_idx) : '0;
    best_producer = found_r ? best_prod : '0;
    similarity    = found_r ? best_sim : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= TOP_IDLE;
      vector_dim  <= DIM_RESET;
      entry_count <= '0;
      ptr         <= '0;
      rd_v        <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= (state == TOP_MAC);
      if (cfg_valid && cfg_ready) vector_dim <= cfg_data;
      if (accept && !(cmd == CMD_REGISTER && full)) begin
        ptr <= is_last ? '0 : ptr + DIM_W'(1);
        if (cmd == CMD_REGISTER && is_last) entry_count <= entry_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_REGISTER && !full) begin
      entry_store[{entry_count[ENTRY_W-1:0], ptr}] <= component_value;
      if (is_last) entry_producers[entry_count[ENTRY_W-1:0]] <= producer_id;
    end
    if (accept && cmd == CMD_QUERY) query_buffer[ptr] <= component_value;
    e_rdata <= entry_store[{idx, j}];
    q_rdata <= query_buffer[j];
    p_rdata <= entry_producers[idx];
  end

  assign qv = $signed(q_rdata);
  assign ev = $signed(e_rdata);
  assign qe = qv * ev;
  assign qq = qv * qv;
  assign ee = ev * ev;

  always_ff @(posedge clk) begin
    j <= (state == TOP_MAC) ? j + DIM_W'(1) : '0;
    if (acc_clr) begin
      dot <= '0;
      nq  <= '0;
      ne  <= '0;
    end else if (rd_v) begin
      dot <= dot + DOT_W'(qe);
      nq  <= nq + NRM_W'($unsigned(qq));
      ne  <= ne + NRM_W'($unsigned(ee));
    end
    if (scan_go) begin
      idx       <= '0;
      found_r   <= 1'b0;
      best_idx  <= '0;
      best_prod <= '0;
      best_sim  <= 16'sh8000;
    end else if (state == TOP_WAIT && sim_done) begin
      idx <= idx + ENTRY_W'(1);
      if (sim > best_sim) begin
        found_r   <= 1'b1;
        best_idx  <= idx;
        best_prod <= p_rdata;
        best_sim  <= sim;
      end
    end
  end

  cnm_sim_unit u_sim (
    .clk  (clk),
    .rst  (rst),
    .go   (sim_go),
    .dot  (dot),
    .nq   (nq),
    .ne   (ne),
    .done (sim_done),
    .sim  (sim)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");
  a_result_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !busy)
    else $error("block stays busy after a result");
  a_found_nonempty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && found) |-> entry_count != '0)
    else $error("match reported on an empty table");
  a_sim_done_wait: assert property (@(posedge clk) disable iff (rst)
    sim_done |-> state == TOP_WAIT)
    else $error("similarity finished outside the wait state");
`endif
endmodule
`default_nettype wire
